// File: rtl/core/scd_pkg.sv
package scd_pkg;

    localparam int CYL_W     = 16;
    localparam int SEEK_W    = 17;
    localparam int KEY_W     = CYL_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [SEEK_W-1:0] SEEK_MAX = 17'h1FFFF;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_DISK_END = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP = 2'd1;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    // service classes, lowest served first
    localparam logic [1:0] CLS_HEAD   = 2'd0;
    localparam logic [1:0] CLS_FIRST  = 2'd1;
    localparam logic [1:0] CLS_SECOND = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr;
        logic mark;
    } store_ctrl_t;

    // Rank of a cylinder in SCAN service order; the smallest key goes next.
    function automatic logic [KEY_W-1:0] rank_key(
        input logic [CYL_W-1:0] v,
        input logic [CYL_W-1:0] head,
        input logic             up
    );
        logic [KEY_W-1:0] k;
        if (v == head) begin
            k = {CLS_HEAD, {CYL_W{1'b0}}};
        end else if (up) begin
            k = (v > head) ? {CLS_FIRST, v} : {CLS_SECOND, ~v};
        end else begin
            k = (v < head) ? {CLS_FIRST, ~v} : {CLS_SECOND, v};
        end
        return k;
    endfunction

endpackage

// File: rtl/core/scd_store.sv
module scd_store
    import scd_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  store_ctrl_t       ctrl,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [CYL_W-1:0]  wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic [IDX_W-1:0]  mark_addr,
    output logic [CYL_W-1:0]  rd_data,
    output logic              rd_served
);

    logic [CYL_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] served_reg;
    logic [CYL_W-1:0] rd_data_reg;
    logic             rd_served_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // served flags: clear at run start, set per emitted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg    <= '0;
            rd_served_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr)
            begin
                served_reg <= '0;
            end
            else if (ctrl.mark)
            begin
                served_reg[mark_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_served_reg <= served_reg[rd_addr];
            end
        end
    end

    assign rd_data   = rd_data_reg;
    assign rd_served = rd_served_reg;

endmodule

// File: rtl/core/scan_disk_scheduler.sv
// SCAN (elevator) disk scheduler.
// A run with N stored requests emits N+1 results; for N > 0 each step reads every stored
// entry in turn through the single read port, compares each entry read, makes an end-of-scan
// check and emits; for N = 0 each step is an end-of-scan check and an emit.
// busy holds for all N+1 steps and drops as the last result appears; results cannot stall.
// Reset: request count cleared, disk_end = 65535, sweep_up = 1.
module scan_disk_scheduler
    import scd_pkg::*;
#(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [CYL_W-1:0]     cylinder,
    output logic                 result_valid,
    output logic [CYL_W-1:0]     position,
    output logic [SEEK_W-1:0]    seek_total,
    output logic                 last,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CYL_W-1:0]     wr_data
);

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int REM_W = $clog2(MAX_REQUESTS + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // configuration
    logic [CYL_W-1:0]  disk_end_reg;
    logic              sweep_up_reg;

    // control
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [REM_W-1:0]  remain_reg, remain_next;
    logic              end_served_reg, end_served_next;
    logic              result_valid_reg, result_valid_next;

    // payload
    logic [CYL_W-1:0]  head_reg, head_next;
    logic [CYL_W-1:0]  pos_reg, pos_next;
    logic [SEEK_W-1:0] total_reg, total_next;
    logic              last_reg, last_next;
    logic              best_valid_reg, best_valid_next;
    logic              best_is_end_reg, best_is_end_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [CYL_W-1:0]  best_cyl_reg, best_cyl_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;

    // store interface
    store_ctrl_t       st_ctrl;
    logic [CYL_W-1:0]  st_rd_data;
    logic              st_rd_served;

    logic              accept;
    logic [CYL_W-1:0]  end_cyl;
    logic [KEY_W-1:0]  end_key;
    logic [KEY_W-1:0]  cand_key;
    logic [CYL_W-1:0]  seek_step;
    logic [SEEK_W:0]   seek_sum;

    scd_store #(
        .DEPTH (MAX_REQUESTS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (st_ctrl),
        .wr_addr   (count_reg[IDX_W-1:0]),
        .wr_data   (cylinder),
        .rd_addr   (rd_idx_reg[IDX_W-1:0]),
        .mark_addr (best_idx_reg),
        .rd_data   (st_rd_data),
        .rd_served (st_rd_served)
    );

    assign accept = start && !busy;

    // The end point is a virtual request that never lives in the memory.
    assign end_cyl  = sweep_up_reg ? disk_end_reg : '0;
    assign end_key  = sweep_up_reg ? {CLS_FIRST, disk_end_reg} : {CLS_FIRST, {CYL_W{1'b1}}};
    assign cand_key = rank_key(st_rd_data, head_reg, sweep_up_reg);

    // Seek step toward the selected cylinder; the running total saturates at SEEK_MAX.
    assign seek_step = (best_cyl_reg >= pos_reg) ? (best_cyl_reg - pos_reg)
                                                 : (pos_reg - best_cyl_reg);
    assign seek_sum  = {1'b0, total_reg} + {{(SEEK_W + 1 - CYL_W){1'b0}}, seek_step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_end_reg <= {CYL_W{1'b1}};
            sweep_up_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_DISK_END)
            begin
                disk_end_reg <= wr_data;
            end
            else if (wr_index == REG_SWEEP_UP)
            begin
                sweep_up_reg <= wr_data[0];
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        run_cnt_next      = run_cnt_reg;
        rd_idx_next       = rd_idx_reg;
        cmp_valid_next    = 1'b0;
        remain_next       = remain_reg;
        end_served_next   = end_served_reg;
        result_valid_next = 1'b0;
        head_next         = head_reg;
        pos_next          = pos_reg;
        total_next        = total_reg;
        last_next         = last_reg;
        best_valid_next   = best_valid_reg;
        best_is_end_next  = best_is_end_reg;
        best_key_next     = best_key_reg;
        best_cyl_next     = best_cyl_reg;
        best_idx_next     = best_idx_reg;
        st_ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_LOAD)
                begin
                    // drop loads once the store is full
                    if (count_reg < CNT_W'(MAX_REQUESTS))
                    begin
                        st_ctrl.wr_en = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                else if (accept && req_type == REQ_RUN)
                begin
                    run_cnt_next     = count_reg;
                    count_next       = '0;
                    remain_next      = REM_W'(count_reg) + REM_W'(1);
                    head_next        = cylinder;
                    pos_next         = cylinder;
                    total_next       = '0;
                    end_served_next  = 1'b0;
                    st_ctrl.clr      = 1'b1;
                    rd_idx_next      = '0;
                    best_valid_next  = 1'b1;
                    best_is_end_next = 1'b1;
                    best_key_next    = end_key;
                    best_cyl_next    = end_cyl;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, compare the entry read last cycle
                if (rd_idx_reg < run_cnt_reg)
                begin
                    st_ctrl.rd_en  = 1'b1;
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end
                if (cmp_valid_reg && !st_rd_served &&
                    (!best_valid_reg || cand_key < best_key_reg))
                begin
                    best_valid_next  = 1'b1;
                    best_is_end_next = 1'b0;
                    best_key_next    = cand_key;
                    best_cyl_next    = st_rd_data;
                    best_idx_next    = cmp_idx_reg;
                end
                if (!(rd_idx_reg < run_cnt_reg) && !cmp_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                result_valid_next = 1'b1;
                pos_next          = best_cyl_reg;
                total_next        = (seek_sum > {1'b0, SEEK_MAX}) ? SEEK_MAX
                                                                  : seek_sum[SEEK_W-1:0];
                last_next         = (remain_reg == REM_W'(1));
                remain_next       = remain_reg - REM_W'(1);
                if (best_is_end_reg)
                begin
                    end_served_next = 1'b1;
                end
                else
                begin
                    st_ctrl.mark = 1'b1;
                end
                // rearm the search for the next step
                rd_idx_next      = '0;
                best_valid_next  = !(best_is_end_reg || end_served_reg);
                best_is_end_next = 1'b1;
                best_key_next    = end_key;
                best_cyl_next    = end_cyl;
                state_next       = (remain_reg == REM_W'(1)) ? ST_IDLE : ST_SCAN;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            run_cnt_reg      <= '0;
            rd_idx_reg       <= '0;
            cmp_valid_reg    <= 1'b0;
            remain_reg       <= '0;
            end_served_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            best_valid_reg   <= 1'b0;
            best_is_end_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            run_cnt_reg      <= run_cnt_next;
            rd_idx_reg       <= rd_idx_next;
            cmp_valid_reg    <= cmp_valid_next;
            remain_reg       <= remain_next;
            end_served_reg   <= end_served_next;
            result_valid_reg <= result_valid_next;
            best_valid_reg   <= best_valid_next;
            best_is_end_reg  <= best_is_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= rd_idx_reg[IDX_W-1:0];
        head_reg     <= head_next;
        pos_reg      <= pos_next;
        total_reg    <= total_next;
        last_reg     <= last_next;
        best_key_reg <= best_key_next;
        best_cyl_reg <= best_cyl_next;
        best_idx_reg <= best_idx_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign position     = pos_reg;
    assign seek_total   = total_reg;
    assign last         = last_reg;

    // A run ends only with its final result transaction.
    a_busy_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last))
        else $error("run ended without a last result");

    // The request store is empty once a run has delivered its last result.
    a_store_emptied: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> (count_reg == '0))
        else $error("request count not cleared after run");

    // A run transaction always makes the block busy.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_RUN) |=> busy)
        else $error("run transaction did not start a scan");

    // Every scan step ends with a selected entry to emit.
    a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> best_valid_reg)
        else $error("emit step without a selected request");

endmodule
